// ===== design/tsla_pkg.sv =====
// Package: shared types and constants of the TDMA slot lease allocator.
package tsla_pkg;

	localparam int TableSlotsDef = 255;
	localparam logic [7:0] AckDone = 8'd254;
	localparam logic [7:0] AckNew  = 8'd253;
	localparam logic [7:0] AckMod  = 8'd253;
	localparam logic [7:0] LeaseDefReset = 8'd10;

	localparam logic [1:0] CfgOffset = 2'd0;
	localparam logic [1:0] CfgCount  = 2'd1;
	localparam logic [1:0] CfgLease  = 2'd2;

	localparam logic FuncRequest = 1'b0;
	localparam logic FuncCheck   = 1'b1;

	typedef struct packed {
		logic       func;
		logic [7:0] node_id;
	} tsla_in_t;

	typedef struct packed {
		logic       granted;
		logic [7:0] slot_id;
		logic [7:0] run_len;
		logic [7:0] min_lease;
		logic [7:0] ack_id;
	} tsla_out_t;

	// one table entry: owner, lease, ack mark
	typedef struct packed {
		logic [7:0] owner;
		logic [7:0] lease;
		logic [7:0] ack;
	} tsla_entry_t;

endpackage

// ===== design/tdma_slot_lease_allocator_core.sv =====
// Top level: TDMA slot lease allocator with sequenced table walks.
//
// channel | direction | handshake          | payload
// in      | in        | start / busy       | in_item  (func, node_id)
// out     | out       | done strobe        | out_item (granted, slot_id, run_len, ...)
// cfg     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Every slot visited takes a read state and a data state (issue the read, then
// act on the data) through the single read port of the table RAM. An item is a
// find pass and then a probe, grow or check walk; the worst case is a fresh node
// whose request scans and then probes the whole range, followed by the done and
// idle states before the next accept.
// After reset a clearing pass writes every RAM row; busy
// stays high meanwhile, configuration writes are taken at any time.
// The result strobe lasts one cycle; the receiver cannot stall it.
module tdma_slot_lease_allocator_core
	#(
	parameter int TableSlots = tsla_pkg::TableSlotsDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  tsla_pkg::tsla_in_t  in_item,
	output logic                done,
	output tsla_pkg::tsla_out_t out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_data
);
	import tsla_pkg::*;

	localparam int AW = $clog2(TableSlots + 1);

	// sequencer codes
	localparam logic [3:0] StClear = 4'd0;
	localparam logic [3:0] StIdle  = 4'd1;
	localparam logic [3:0] StFindR = 4'd2; // issue read for find
	localparam logic [3:0] StFindD = 4'd3; // evaluate find data
	localparam logic [3:0] StProbR = 4'd4;
	localparam logic [3:0] StProbD = 4'd5;
	localparam logic [3:0] StUpR   = 4'd6;
	localparam logic [3:0] StUpD   = 4'd7;
	localparam logic [3:0] StDnR   = 4'd8;
	localparam logic [3:0] StDnD   = 4'd9;
	localparam logic [3:0] StChkR  = 4'd10;
	localparam logic [3:0] StChkD  = 4'd11;
	localparam logic [3:0] StAckR  = 4'd12; // rewrite first slot with ack number
	localparam logic [3:0] StAckD  = 4'd13;
	localparam logic [3:0] StDone  = 4'd14;

	logic [3:0]    state_q;
	logic [7:0]    off_q, cnt_q, lease_def_q, ack_ctr_q;
	logic          func_q;
	logic [7:0]    node_q;
	logic [AW-1:0] cur_q, first_q, pos_q, iter_q;
	logic [7:0]    len_q, minl_q;
	logic          need_q;
	tsla_out_t     res_q;

	// range end = off + min(cnt, TableSlots-off), or off when off is past the table
	logic [8:0] off9, cnt9, room9, end9, span9;
	always_comb begin
		off9  = {1'b0, off_q};
		cnt9  = {1'b0, cnt_q};
		room9 = 9'(TableSlots) - off9;
		if (off9 >= 9'(TableSlots)) begin
			end9 = off9;
		end else if (cnt9 > room9) begin
			end9 = 9'(TableSlots);
		end else begin
			end9 = off9 + cnt9;
		end
		span9 = end9 - off9;
	end

	// table RAM
	logic          we;
	logic [AW-1:0] waddr, raddr;
	tsla_entry_t   wdata, rdata;

	tsla_ram #(.Width($bits(tsla_entry_t)), .Depth(TableSlots)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr[$clog2(TableSlots)-1:0]),
		.wdata (wdata),
		.raddr (raddr[$clog2(TableSlots)-1:0]),
		.rdata (rdata)
	);

	logic own_live;
	assign own_live = (rdata.owner == node_q) && (rdata.lease != 8'd0);

	// stride-2 probe step, modulo span (pos < span, so one subtract suffices unless span is one)
	logic [8:0] pos_nx;
	always_comb begin
		pos_nx = {1'b0, 8'(pos_q)} + 9'd2;
		if (pos_nx >= span9) begin
			pos_nx = pos_nx - span9;
		end
		if (pos_nx >= span9) begin
			pos_nx = 9'd0; // span of one
		end
	end

	// next ack number modulo 253; the reset value 253 steps to 1
	logic [7:0] ack_inc, ack_nx;
	assign ack_inc = ack_ctr_q + 8'd1;
	assign ack_nx  = (ack_inc >= AckMod) ? ack_inc - AckMod : ack_inc;

	assign busy      = (state_q != StIdle);
	assign cfg_ready = 1'b1;
	assign done      = (state_q == StDone);
	assign out_item  = res_q;

	// read address and write port
	always_comb begin
		raddr = cur_q;
		we    = 1'b0;
		waddr = cur_q;
		wdata = rdata;
		unique case (state_q)
			StClear: begin
				we    = 1'b1;
				wdata = '{owner: 8'd0, lease: 8'd0, ack: AckDone};
			end
			StProbR: raddr = AW'(off9 + {1'b0, 8'(pos_q)});
			StProbD: begin
				waddr = AW'(off9 + {1'b0, 8'(pos_q)});
				if (rdata.lease == 8'd0) begin
					we    = 1'b1;
					wdata = '{owner: node_q, lease: lease_def_q, ack: AckNew};
				end
			end
			// the downward step moves cur_q at this edge, so read the slot below
			StDnR: raddr = cur_q - AW'(1);
			StUpD, StDnD: begin
				if (rdata.lease == 8'd0) begin
					we    = 1'b1;
					wdata = '{owner: node_q, lease: lease_def_q, ack: AckNew};
				end
			end
			StChkD: begin
				if (own_live && ({1'b0, 8'(cur_q)} < end9)) begin
					we    = 1'b1;
					wdata = '{owner: rdata.owner, lease: rdata.lease - 8'd1,
						ack: AckDone};
				end
			end
			StAckR: raddr = first_q;
			StAckD: begin
				waddr = first_q;
				we    = 1'b1;
				wdata = '{owner: rdata.owner, lease: rdata.lease, ack: ack_ctr_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StClear;
			off_q       <= 8'd0;
			cnt_q       <= 8'd0;
			lease_def_q <= LeaseDefReset;
			ack_ctr_q   <= AckNew;
			cur_q       <= '0;
			res_q       <= '0;
			func_q      <= FuncRequest;
			node_q      <= 8'd0;
			first_q     <= '0;
			pos_q       <= '0;
			iter_q      <= '0;
			len_q       <= 8'd0;
			minl_q      <= 8'd255;
			need_q      <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CfgOffset: off_q       <= cfg_data;
					CfgCount:  cnt_q       <= cfg_data;
					CfgLease:  lease_def_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				StClear: begin
					if (cur_q == AW'(TableSlots - 1)) begin
						state_q <= StIdle;
					end
					cur_q <= cur_q + AW'(1);
				end
				StIdle: begin
					if (start) begin
						func_q <= in_item.func;
						node_q <= in_item.node_id;
						res_q  <= '0;
						cur_q  <= AW'(off9);
						len_q  <= 8'd0;
						minl_q <= 8'd255;
						need_q <= 1'b0;
						state_q <= (end9 <= off9) ? StDone : StFindR;
					end
				end
				StFindR: state_q <= StFindD;
				StFindD: begin
					if (own_live) begin
						first_q <= cur_q;
						if (func_q == FuncCheck) begin
							state_q <= StChkR;
						end else if ({1'b0, 8'(cur_q)} + 9'd1 < end9) begin
							cur_q   <= cur_q + AW'(1);
							state_q <= StUpR;
						end else begin
							state_q <= StDnR;
						end
					end else if ({1'b0, 8'(cur_q)} + 9'd1 >= end9) begin
						if (func_q == FuncCheck) begin
							state_q <= StDone;
						end else begin
							pos_q   <= '0;
							iter_q  <= '0;
							state_q <= StProbR;
						end
					end else begin
						cur_q   <= cur_q + AW'(1);
						state_q <= StFindR;
					end
				end
				StProbR: state_q <= StProbD;
				StProbD: begin
					if (rdata.lease == 8'd0) begin
						res_q.granted <= 1'b1;
						res_q.slot_id <= 8'(off9 + {1'b0, 8'(pos_q)});
						state_q <= StDone;
					end else if ({1'b0, 8'(iter_q)} + 9'd1 >= span9) begin
						state_q <= StDone;
					end else begin
						iter_q  <= iter_q + AW'(1);
						pos_q   <= AW'(pos_nx);
						state_q <= StProbR;
					end
				end
				StUpR: state_q <= StUpD;
				StUpD: begin
					if (rdata.lease == 8'd0) begin
						res_q.granted <= 1'b1;
						res_q.slot_id <= 8'(cur_q);
						state_q <= StDone;
					end else if (rdata.owner != node_q ||
						{1'b0, 8'(cur_q)} + 9'd1 >= end9) begin
						cur_q   <= first_q;
						state_q <= StDnR;
					end else begin
						cur_q   <= cur_q + AW'(1);
						state_q <= StUpR;
					end
				end
				StDnR: begin
					// step down first; stop at offset
					if ({1'b0, 8'(cur_q)} <= off9) begin
						state_q <= StDone;
					end else begin
						cur_q   <= cur_q - AW'(1);
						state_q <= StDnD;
					end
				end
				StDnD: begin
					if (rdata.lease == 8'd0) begin
						res_q.granted <= 1'b1;
						res_q.slot_id <= 8'(cur_q);
						state_q <= StDone;
					end else if (rdata.owner != node_q) begin
						state_q <= StDone;
					end else begin
						state_q <= StDnR;
					end
				end
				StChkR: state_q <= StChkD;
				StChkD: begin
					if (own_live && ({1'b0, 8'(cur_q)} < end9)) begin
						if (rdata.lease < minl_q) begin
							minl_q <= rdata.lease;
						end
						if (rdata.ack != AckDone) begin
							need_q <= 1'b1;
						end
						len_q   <= len_q + 8'd1;
						cur_q   <= cur_q + AW'(1);
						state_q <= ({1'b0, 8'(cur_q)} + 9'd1 < end9) ? StChkR : StAckR;
					end else begin
						state_q <= StAckR;
					end
				end
				StAckR: begin
					if (need_q) begin
						ack_ctr_q <= ack_nx;
						state_q   <= StAckD;
					end else begin
						state_q <= StDone;
					end
				end
				StAckD: begin
					res_q   <= '{granted: 1'b1, slot_id: 8'(first_q), run_len: len_q,
						min_lease: minl_q, ack_id: ack_ctr_q};
					state_q <= StDone;
				end
				StDone:  state_q <= StIdle;
				default: state_q <= StIdle;
			endcase
		end
	end

	// checks
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_ack_range: assert property (@(posedge clk) disable iff (!arst_n)
		ack_ctr_q < AckMod || ack_ctr_q == AckNew) else $error("ack counter out of range");
	a_nogrant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !out_item.granted) |-> (out_item.slot_id == 8'd0 &&
		out_item.run_len == 8'd0)) else $error("ungranted result not zero");
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("item accepted but not busy");
endmodule

// ===== design/tsla_ram.sv =====
// Generic RAM with one write port and one registered read port.
module tsla_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
